### sv/pdhh_pkg.sv
// shared types, register map and constants of the heading hold core
package pdhh_pkg;

    localparam int YAW_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int DRIVE_W  = 10;
    localparam int CMD_W    = 11;
    localparam int TOL_W    = 15;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;
    localparam int REG_IDX_W = 3;

    // one full turn is 46080 counts of 1/128 degree
    localparam int TURN_COUNTS = 46080;
    localparam int HALF_TURN   = 23040;
    localparam int GAIN_SHIFT  = 15;
    localparam int DRIVE_LIMIT = 1023;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_TARGET_YAW = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DAMP_GAIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_DRIVE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DRIVE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ARRIVE_TOL = 3'd5;

    // reset values
    localparam logic [YAW_W-1:0]   RST_TARGET_YAW = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 16'd3840;
    localparam logic [GAIN_W-1:0]  RST_DAMP_GAIN  = 16'd1792;
    localparam logic [DRIVE_W-1:0] RST_MIN_DRIVE  = 10'd40;
    localparam logic [DRIVE_W-1:0] RST_MAX_DRIVE  = 10'd500;
    localparam logic [TOL_W-1:0]   RST_ARRIVE_TOL = 15'd256;

    typedef struct packed {
        logic [YAW_W-1:0]   target_yaw;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  damp_gain;
        logic [DRIVE_W-1:0] min_drive;
        logic [DRIVE_W-1:0] max_drive;
        logic [TOL_W-1:0]   arrive_tolerance;
    } pdhh_cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] left_drive;
        logic [CMD_W-1:0] right_drive;
        logic             arrived;
    } pdhh_result_t;

endpackage

### sv/pdhh_regs.sv
// configuration register file with its apb-style access port
module pdhh_regs
    import pdhh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output pdhh_cfg_t         cfg
);

    pdhh_cfg_t              cfg_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_yaw       <= RST_TARGET_YAW;
            cfg_reg.prop_gain        <= RST_PROP_GAIN;
            cfg_reg.damp_gain        <= RST_DAMP_GAIN;
            cfg_reg.min_drive        <= RST_MIN_DRIVE;
            cfg_reg.max_drive        <= RST_MAX_DRIVE;
            cfg_reg.arrive_tolerance <= RST_ARRIVE_TOL;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TARGET_YAW: cfg_reg.target_yaw       <= pwdata[YAW_W-1:0];
                REG_PROP_GAIN:  cfg_reg.prop_gain        <= pwdata[GAIN_W-1:0];
                REG_DAMP_GAIN:  cfg_reg.damp_gain        <= pwdata[GAIN_W-1:0];
                REG_MIN_DRIVE:  cfg_reg.min_drive        <= pwdata[DRIVE_W-1:0];
                REG_MAX_DRIVE:  cfg_reg.max_drive        <= pwdata[DRIVE_W-1:0];
                REG_ARRIVE_TOL: cfg_reg.arrive_tolerance <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TARGET_YAW: prdata = {{(APB_W-YAW_W){1'b0}}, cfg_reg.target_yaw};
            REG_PROP_GAIN:  prdata = {{(APB_W-GAIN_W){1'b0}}, cfg_reg.prop_gain};
            REG_DAMP_GAIN:  prdata = {{(APB_W-GAIN_W){1'b0}}, cfg_reg.damp_gain};
            REG_MIN_DRIVE:  prdata = {{(APB_W-DRIVE_W){1'b0}}, cfg_reg.min_drive};
            REG_MAX_DRIVE:  prdata = {{(APB_W-DRIVE_W){1'b0}}, cfg_reg.max_drive};
            REG_ARRIVE_TOL: prdata = {{(APB_W-TOL_W){1'b0}}, cfg_reg.arrive_tolerance};
            default:        prdata = '0;
        endcase
    end

endmodule

### sv/pdhh_calc.sv
// pd controller datapath: heading error, damping term, deadband and clamp
module pdhh_calc
    import pdhh_pkg::*;
(
    input  pdhh_cfg_t          cfg,
    input  logic [YAW_W-1:0]   yaw,
    input  logic               sensor_ready,
    input  logic               restart,
    input  logic [YAW_W-1:0]   prev_yaw,
    output pdhh_result_t       result,
    output logic [YAW_W-1:0]   prev_yaw_next
);

    localparam logic signed [YAW_W:0] HALF_S = (YAW_W+1)'(HALF_TURN);
    localparam logic signed [YAW_W:0] TURN_S = (YAW_W+1)'(TURN_COUNTS);

    logic signed [YAW_W:0]     diff;
    logic signed [YAW_W:0]     wrapped;
    logic signed [YAW_W-1:0]   err;
    logic        [YAW_W-1:0]   err_abs;
    logic        [YAW_W-1:0]   prev_eff;
    logic signed [YAW_W:0]     delta;
    logic signed [GAIN_W:0]    kp_s;
    logic signed [GAIN_W:0]    kd_s;
    logic signed [32:0]        prod_p;
    logic signed [33:0]        prod_d;
    logic signed [34:0]        pd_sum;
    logic                      neg;
    logic        [34:0]        pd_mag;
    logic        [19:0]        pd_shr;
    logic        [DRIVE_W-1:0] mag_sat;
    logic        [DRIVE_W-1:0] mag_db;
    logic        [DRIVE_W-1:0] mag_lim;
    logic        [CMD_W-1:0]   drive;

    // wrap the heading error into the half-open turn, one correction suffices
    assign diff = $signed({cfg.target_yaw[YAW_W-1], cfg.target_yaw})
                - $signed({yaw[YAW_W-1], yaw});

    always_comb begin
        if (diff >= HALF_S) begin
            wrapped = diff - TURN_S;
        end else if (diff < -HALF_S) begin
            wrapped = diff + TURN_S;
        end else begin
            wrapped = diff;
        end
    end

    assign err     = wrapped[YAW_W-1:0];
    assign err_abs = err[YAW_W-1] ? YAW_W'(-err) : YAW_W'(err);

    // restart reseeds the previous heading so that the change is zero
    assign prev_eff = restart ? yaw : prev_yaw;
    assign delta    = $signed({yaw[YAW_W-1], yaw}) - $signed({prev_eff[YAW_W-1], prev_eff});

    assign kp_s   = $signed({1'b0, cfg.prop_gain});
    assign kd_s   = $signed({1'b0, cfg.damp_gain});
    assign prod_p = err * kp_s;
    assign prod_d = delta * kd_s;
    assign pd_sum = 35'(prod_p) - 35'(prod_d);

    assign neg    = pd_sum[34];
    assign pd_mag = neg ? 35'(-pd_sum) : 35'(pd_sum);
    assign pd_shr = pd_mag[34:GAIN_SHIFT];

    always_comb begin
        if (pd_shr > 20'(DRIVE_LIMIT)) begin
            mag_sat = DRIVE_W'(DRIVE_LIMIT);
        end else begin
            mag_sat = pd_shr[DRIVE_W-1:0];
        end
        // small nonzero drive is raised to the deadband edge
        if (mag_sat != '0 && mag_sat < cfg.min_drive) begin
            mag_db = cfg.min_drive;
        end else begin
            mag_db = mag_sat;
        end
        // the limit is applied last and wins
        if (mag_db > cfg.max_drive) begin
            mag_lim = cfg.max_drive;
        end else begin
            mag_lim = mag_db;
        end
        if (!sensor_ready) begin
            drive = '0;
        end else if (neg) begin
            drive = CMD_W'(-{1'b0, mag_lim});
        end else begin
            drive = {1'b0, mag_lim};
        end
    end

    assign result.right_drive = drive;
    assign result.left_drive  = CMD_W'(-drive);
    assign result.arrived     = (err_abs[TOL_W-1:0] < cfg.arrive_tolerance);

    assign prev_yaw_next = (sensor_ready || restart) ? yaw : prev_yaw;

endmodule

### sv/pd_heading_hold_core.sv
// top level of the pd heading hold core: stream pipeline and previous heading state
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: yaw; tuser: sensor_ready, restart
//  m_axis    out  tvalid/tready          tdata: left, right drive; tuser: arrived
//  apb       in   psel/penable/pready    six config registers at 4*i
//
// one item per cycle sustained while m_axis_tready is high; an accepted item passes
// the input register, then the result register after the single-pass datapath
// reset clears both valid stages, the previous heading and the registers
// a stalled result holds in the result register while the input register still
// takes one more item; s_axis_tready drops only when both are full
module pd_heading_hold_core
    import pdhh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [15:0] yaw
    input  logic [1:0]        s_axis_tuser,   // [0] sensor_ready, [1] restart
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [10:0] left_drive, [21:11] right_drive, pad
    output logic              m_axis_tuser,   // [0] arrived
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    pdhh_cfg_t          cfg;
    pdhh_result_t       calc_res;
    logic [YAW_W-1:0]   prev_yaw_next;

    logic               in_valid_reg;
    logic [YAW_W-1:0]   in_yaw_reg;
    logic               in_ready_reg;
    logic               in_restart_reg;
    logic [YAW_W-1:0]   prev_yaw_reg;
    logic               out_valid_reg;
    pdhh_result_t       out_res_reg;
    logic               advance;

    pdhh_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdhh_calc u_calc (
        .cfg           (cfg),
        .yaw           (in_yaw_reg),
        .sensor_ready  (in_ready_reg),
        .restart       (in_restart_reg),
        .prev_yaw      (prev_yaw_reg),
        .result        (calc_res),
        .prev_yaw_next (prev_yaw_next)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_yaw_reg  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                // state moves with the item that leaves the input register
                if (in_valid_reg) begin
                    prev_yaw_reg <= prev_yaw_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_yaw_reg     <= s_axis_tdata[YAW_W-1:0];
            in_ready_reg   <= s_axis_tuser[0];
            in_restart_reg <= s_axis_tuser[1];
        end
        if (advance && in_valid_reg) begin
            out_res_reg <= calc_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_res_reg.right_drive, out_res_reg.left_drive};
    assign m_axis_tuser  = out_res_reg.arrived;

endmodule

### sv/pdhh_checker.sv
// port-level checker for the heading hold core, with its bind
module pdhh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // pipeline is empty and open right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_axis_tvalid && s_axis_tready))
        else $error("pipeline not empty after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // wheels always get opposite commands and the pad stays clear
    a_drive_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((m_axis_tdata[10:0] + m_axis_tdata[21:11]) == 11'd0
                           && m_axis_tdata[23:22] == 2'b00))
        else $error("left and right drive not mirrored");

endmodule

bind pd_heading_hold_core pdhh_checker u_pdhh_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
